[sv/ttip_pkg.sv]
// Shared types, constants and the character decoder for the text-to-integer parser.
package ttip_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned DIGIT_W = 7;
    localparam int unsigned PROD_W  = VALUE_W + BASE_W;

    localparam logic [POS_W-1:0]   MAX_POSITION = 16'hFFFF;
    localparam logic [DIGIT_W-1:0] NOT_DIGIT    = 7'd99;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    localparam logic [VALUE_W-1:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] SIGNED_MIN = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] UNSIGNED_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic REG_RADIX       = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    typedef enum logic [6:0] {
        ST_WS     = 7'b0000001,
        ST_START  = 7'b0000010,
        ST_ZERO   = 7'b0000100,
        ST_XSEEN  = 7'b0001000,
        ST_DIGITS = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    // how the working base changes on this character
    typedef enum logic [1:0] {
        BOP_KEEP   = 2'd0,
        BOP_START  = 2'd1,
        BOP_PREFIX = 2'd2,
        BOP_HEX    = 2'd3
    } base_op_t;

    typedef struct packed {
        base_op_t base_op;
        logic     set_neg;
        logic     take;
        logic     mark_zero;
        logic     advance;
        logic     finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_ws;
        logic is_sign;
        logic is_minus;
        logic is_zero;
        logic is_x;
        logic radix_pfx;
        logic lt_start;
        logic lt_base;
        logic lt_hex;
    } dp_status_t;

    function automatic logic [DIGIT_W-1:0] digit_val(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] v;
        v = NOT_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            v = DIGIT_W'(c - CH_LO_A) + 7'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            v = DIGIT_W'(c - CH_UP_A) + 7'd10;
        end
        return v;
    endfunction

endpackage

[sv/ttip_ctrl.sv]
// Parse-phase state machine and result handshake control.
module ttip_ctrl
    import ttip_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    state_t phase_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   can_load;
    logic   go_start;
    logic   go_digits;

    assign s_ready  = (state_reg != ST_FINISH);
    assign accept   = s_valid && s_ready;
    assign can_load = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.base_op = BOP_KEEP;
        state_next  = state_reg;
        phase_next  = state_reg;
        go_start    = 1'b0;
        go_digits   = 1'b0;

        if (accept) begin
            cmd.advance = 1'b1;
            unique case (state_reg)
                ST_WS: begin
                    if (status.is_ws) begin
                        phase_next = ST_WS;
                    end else if (status.is_sign) begin
                        cmd.set_neg = status.is_minus;
                        phase_next  = ST_START;
                    end else begin
                        go_start = 1'b1;
                    end
                end
                ST_START: go_start = 1'b1;
                ST_ZERO: begin
                    if (status.is_x) begin
                        phase_next = ST_XSEEN;
                    end else begin
                        go_digits = 1'b1;
                    end
                end
                ST_XSEEN: begin
                    cmd.base_op = BOP_HEX;
                    if (status.lt_hex) begin
                        cmd.take   = 1'b1;
                        phase_next = ST_DIGITS;
                    end else begin
                        phase_next = ST_DONE;
                    end
                end
                ST_DIGITS: go_digits = 1'b1;
                ST_DONE:   phase_next = ST_DONE;
                ST_FINISH: phase_next = ST_FINISH;
                default:   phase_next = ST_WS;
            endcase

            if (go_start) begin
                if (status.is_zero && status.radix_pfx) begin
                    cmd.base_op   = BOP_PREFIX;
                    cmd.mark_zero = 1'b1;
                    phase_next    = ST_ZERO;
                end else begin
                    cmd.base_op = BOP_START;
                    if (status.lt_start) begin
                        cmd.take   = 1'b1;
                        phase_next = ST_DIGITS;
                    end else begin
                        phase_next = ST_DONE;
                    end
                end
            end

            if (go_digits) begin
                if (status.lt_base) begin
                    cmd.take   = 1'b1;
                    phase_next = ST_DIGITS;
                end else begin
                    phase_next = ST_DONE;
                end
            end

            state_next = s_last ? ST_FINISH : phase_next;
        end else if (state_reg == ST_FINISH && can_load) begin
            // form the result and drop the string state
            cmd.finish = 1'b1;
            state_next = ST_WS;
        end
    end

    always_comb begin
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WS;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_last_goes_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last) |=> (state_reg == ST_FINISH))
        else $error("last word did not lead to result formation");

    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (m_valid_reg && state_reg == ST_WS))
        else $error("result formation did not present a result");

endmodule

[sv/ttip_dpath.sv]
// Character decode, accumulator with overflow tracking, positions and result registers.
module ttip_dpath
    import ttip_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CHAR_W-1:0]   s_ch,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [BASE_W-1:0]   cfg_wr_data,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    output logic [VALUE_W-1:0]  m_value,
    output logic                m_overflow,
    output logic                m_no_number,
    output logic [POS_W-1:0]    m_end_position
);

    logic [BASE_W-1:0]  radix_reg, radix_next;
    logic               signed_mode_reg, signed_mode_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               ovf_reg, ovf_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [POS_W-1:0]   index_reg, index_next;
    logic [POS_W-1:0]   stop_reg, stop_next;
    logic               started_reg, started_next;

    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_no_num_reg, out_no_num_next;
    logic [POS_W-1:0]   out_end_reg, out_end_next;

    logic [DIGIT_W-1:0] dval;
    logic [BASE_W-1:0]  start_base;
    logic [BASE_W-1:0]  prefix_base;
    logic [BASE_W-1:0]  mul_base;
    logic [PROD_W-1:0]  prod;
    logic [POS_W-1:0]   nxt_pos;
    logic               range_ovf;
    logic               fin_ovf;

    assign dval        = digit_val(s_ch);
    assign start_base  = (radix_reg == BASE_AUTO) ? BASE_DEC : radix_reg;
    assign prefix_base = (radix_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;

    assign status.is_ws     = (s_ch == CH_SPACE) || (s_ch >= CH_TAB && s_ch <= CH_CR);
    assign status.is_sign   = (s_ch == CH_PLUS) || (s_ch == CH_MINUS);
    assign status.is_minus  = (s_ch == CH_MINUS);
    assign status.is_zero   = (s_ch == CH_ZERO);
    assign status.is_x      = (s_ch == CH_LO_X) || (s_ch == CH_UP_X);
    assign status.radix_pfx = (radix_reg == BASE_AUTO) || (radix_reg == BASE_HEX);
    assign status.lt_start  = dval < {1'b0, start_base};
    assign status.lt_base   = dval < {1'b0, base_reg};
    assign status.lt_hex    = dval < {1'b0, BASE_HEX};

    always_comb begin
        unique case (cmd.base_op)
            BOP_START:  mul_base = start_base;
            BOP_HEX:    mul_base = BASE_HEX;
            BOP_KEEP:   mul_base = base_reg;
            BOP_PREFIX: mul_base = base_reg;
            default:    mul_base = base_reg;
        endcase
    end

    // any carry above bit 63 means the value no longer fits
    assign prod    = PROD_W'(acc_reg) * PROD_W'(mul_base) + PROD_W'(dval[BASE_W-1:0]);
    assign nxt_pos = (index_reg == MAX_POSITION) ? index_reg : index_reg + 1'b1;

    assign range_ovf = signed_mode_reg &&
                       (neg_reg ? (acc_reg > SIGNED_MIN) : acc_reg[VALUE_W-1]);
    assign fin_ovf   = ovf_reg || range_ovf;

    always_comb begin
        radix_next       = radix_reg;
        signed_mode_next = signed_mode_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RADIX:       radix_next       = cfg_wr_data;
                REG_SIGNED_MODE: signed_mode_next = cfg_wr_data[0];
                default:         radix_next       = radix_reg;
            endcase
        end
    end

    always_comb begin
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        base_next    = base_reg;
        index_next   = index_reg;
        stop_next    = stop_reg;
        started_next = started_reg;

        if (cmd.finish) begin
            acc_next     = '0;
            neg_next     = 1'b0;
            ovf_next     = 1'b0;
            base_next    = '0;
            index_next   = '0;
            stop_next    = '0;
            started_next = 1'b0;
        end else begin
            if (cmd.advance) begin
                index_next = nxt_pos;
            end
            if (cmd.set_neg) begin
                neg_next = 1'b1;
            end
            unique case (cmd.base_op)
                BOP_START:  base_next = start_base;
                BOP_PREFIX: base_next = prefix_base;
                BOP_HEX:    base_next = BASE_HEX;
                BOP_KEEP:   base_next = base_reg;
                default:    base_next = base_reg;
            endcase
            if (cmd.mark_zero) begin
                started_next = 1'b1;
                stop_next    = nxt_pos;
            end
            if (cmd.take) begin
                acc_next     = prod[VALUE_W-1:0];
                ovf_next     = ovf_reg || (|prod[PROD_W-1:VALUE_W]);
                stop_next    = nxt_pos;
                started_next = 1'b1;
            end
        end
    end

    always_comb begin
        out_value_next  = out_value_reg;
        out_ovf_next    = out_ovf_reg;
        out_no_num_next = out_no_num_reg;
        out_end_next    = out_end_reg;
        if (cmd.finish) begin
            if (!started_reg) begin
                out_value_next  = '0;
                out_ovf_next    = 1'b0;
                out_no_num_next = 1'b1;
                out_end_next    = '0;
            end else begin
                if (fin_ovf) begin
                    if (signed_mode_reg) begin
                        out_value_next = neg_reg ? SIGNED_MIN : SIGNED_MAX;
                    end else begin
                        out_value_next = UNSIGNED_MAX;
                    end
                end else begin
                    out_value_next = neg_reg ? (VALUE_W'(0) - acc_reg) : acc_reg;
                end
                out_ovf_next    = fin_ovf;
                out_no_num_next = 1'b0;
                out_end_next    = stop_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg       <= BASE_DEC;
            signed_mode_reg <= 1'b1;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            base_reg        <= '0;
            index_reg       <= '0;
            stop_reg        <= '0;
            started_reg     <= 1'b0;
        end else begin
            radix_reg       <= radix_next;
            signed_mode_reg <= signed_mode_next;
            acc_reg         <= acc_next;
            neg_reg         <= neg_next;
            ovf_reg         <= ovf_next;
            base_reg        <= base_next;
            index_reg       <= index_next;
            stop_reg        <= stop_next;
            started_reg     <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        out_ovf_reg    <= out_ovf_next;
        out_no_num_reg <= out_no_num_next;
        out_end_reg    <= out_end_next;
    end

    assign m_value        = out_value_reg;
    assign m_overflow     = out_ovf_reg;
    assign m_no_number    = out_no_num_reg;
    assign m_end_position = out_end_reg;

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (acc_reg == '0 && !started_reg && index_reg == '0 && !ovf_reg))
        else $error("string state not cleared after result");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && !started_reg) |=>
            (out_no_num_reg && !out_ovf_reg && out_value_reg == '0 && out_end_reg == '0))
        else $error("empty string gave a nonzero result");

endmodule

[sv/text_to_integer_parser.sv]
// Top level of the streaming text-to-integer parser.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_ch[7:0], s_last
//  m_       out        m_valid/m_ready    m_value[63:0], m_overflow, m_no_number,
//                                         m_end_position[15:0]
//  cfg_     in         cfg_wr_en          cfg_index, cfg_wr_data[5:0]
//
// One character word is taken per cycle while s_ready is high; the decode, the 64x6
// multiply-add of the accumulator and its carry-out check are combinational.
// After the last word, ST_FINISH forms the saturated result into the output register.
// s_ready is low in that state, which holds while the previous result has not been taken.
// Reset is synchronous on aresetn: parse state clears, radix returns to 10, signed mode to 1.
module text_to_integer_parser
    import ttip_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CHAR_W-1:0]   s_ch,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VALUE_W-1:0]  m_value,
    output logic                m_overflow,
    output logic                m_no_number,
    output logic [POS_W-1:0]    m_end_position,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [BASE_W-1:0]   cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ttip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ttip_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_ch           (s_ch),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .status         (status),
        .m_value        (m_value),
        .m_overflow     (m_overflow),
        .m_no_number    (m_no_number),
        .m_end_position (m_end_position)
    );

endmodule
